[rtl/utf8v_pkg.sv]
// Shared types and constants for the UTF-8 stream validator.
// Used by the front classifier, the item queue and the back sequencer.
`timescale 1ns / 1ps

package utf8v_pkg;

    // Byte kinds as seen by the back end
    typedef enum logic [2:0] {
        CLS_NUL,
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } t_byte_class;

    // Classified byte: kind, code point bits it carries, end of text flag
    typedef struct packed {
        t_byte_class kind;
        logic [5:0]  bits;
        logic        last;
    } t_item;

    localparam int unsigned ACC_W = 21;

    typedef logic [ACC_W-1:0] t_acc;

    // Verdict codes
    localparam logic [1:0] VERDICT_BUSY    = 2'd0;
    localparam logic [1:0] VERDICT_VALID   = 2'd1;
    localparam logic [1:0] VERDICT_INVALID = 2'd2;

    // Sequence kinds
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    // Code point limits
    localparam t_acc CP_MIN_TWO    = 21'h00080;
    localparam t_acc CP_MIN_THREE  = 21'h00800;
    localparam t_acc CP_MIN_FOUR   = 21'h10000;
    localparam t_acc CP_MAX        = 21'h10FFFF;
    localparam t_acc CP_SURR_LO    = 21'h0D800;
    localparam t_acc CP_SURR_HI    = 21'h0DFFF;

endpackage

[rtl/utf8v_front.sv]
// Front end: takes bytes from the input stream and classifies them.
// Depends on utf8v_pkg; feeds utf8v_queue.
`timescale 1ns / 1ps

module utf8v_front
    import utf8v_pkg::*;
(
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // end_of_text
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    t_item w_item;

    always_comb begin
        w_item.last = i_s_axis_tlast;
        w_item.bits = 6'd0;
        w_item.kind = CLS_BAD;
        if (i_s_axis_tdata == 8'h00) begin
            w_item.kind = CLS_NUL;
        end else if (i_s_axis_tdata[7] == 1'b0) begin
            w_item.kind = CLS_ASCII;
        end else if (i_s_axis_tdata[7:6] == 2'b10) begin
            w_item.kind = CLS_CONT;
            w_item.bits = i_s_axis_tdata[5:0];
        end else if (i_s_axis_tdata[7:5] == 3'b110) begin
            w_item.kind = CLS_LEAD2;
            w_item.bits = {1'b0, i_s_axis_tdata[4:0]};
        end else if (i_s_axis_tdata[7:4] == 4'b1110) begin
            w_item.kind = CLS_LEAD3;
            w_item.bits = {2'b00, i_s_axis_tdata[3:0]};
        end else if (i_s_axis_tdata[7:3] == 5'b11110) begin
            w_item.kind = CLS_LEAD4;
            w_item.bits = {3'b000, i_s_axis_tdata[2:0]};
        end
    end

    // Ready follows queue space only; the reset term keeps the port quiet in reset
    assign o_s_axis_tready = i_rst_n & ~i_q_full;
    assign o_push          = i_s_axis_tvalid & o_s_axis_tready;
    assign o_item          = w_item;

endmodule

[rtl/utf8v_queue.sv]
// Two-entry queue of classified bytes between the front and back ends.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_queue
    import utf8v_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[rtl/utf8v_back.sv]
// Back end: gathers code point bits, checks sequences and registers the verdict.
// Depends on utf8v_pkg; pops utf8v_queue.
`timescale 1ns / 1ps

module utf8v_back
    import utf8v_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [1:0] verdict, [7:2] zero
    output logic       o_m_axis_tlast    // text_done
);

    logic [1:0] r_rem;
    logic [1:0] r_len;
    t_acc       r_acc;
    logic       r_err;
    logic       r_out_valid;
    logic [1:0] r_verdict;
    logic       r_done;

    logic [1:0] n_rem;
    logic [1:0] n_len;
    t_acc       n_acc;
    logic       n_err;
    logic [1:0] n_verdict;
    t_acc       w_shifted;
    t_acc       w_min;

    // Advance when the output slot is free or being emptied this cycle
    assign o_pop = i_q_valid & (~r_out_valid | i_m_axis_tready);

    assign w_shifted = {r_acc[ACC_W-7:0], i_item.bits};

    always_comb begin
        case (r_len)
            SEQ_TWO:   w_min = CP_MIN_TWO;
            SEQ_THREE: w_min = CP_MIN_THREE;
            default:   w_min = CP_MIN_FOUR;
        endcase
    end

    always_comb begin
        n_rem = r_rem;
        n_len = r_len;
        n_acc = r_acc;
        n_err = r_err;
        if (!r_err) begin
            if (r_rem == 2'd0) begin
                case (i_item.kind)
                    CLS_ASCII: ;
                    CLS_LEAD2: begin
                        n_rem = 2'd1;
                        n_len = SEQ_TWO;
                        n_acc = t_acc'(i_item.bits);
                    end
                    CLS_LEAD3: begin
                        n_rem = 2'd2;
                        n_len = SEQ_THREE;
                        n_acc = t_acc'(i_item.bits);
                    end
                    CLS_LEAD4: begin
                        n_rem = 2'd3;
                        n_len = SEQ_FOUR;
                        n_acc = t_acc'(i_item.bits);
                    end
                    default: n_err = 1'b1;
                endcase
            end else if (i_item.kind != CLS_CONT) begin
                n_err = 1'b1;
            end else begin
                n_acc = w_shifted;
                n_rem = r_rem - 2'd1;
                if (r_rem == 2'd1) begin
                    if ((w_shifted < w_min) || (w_shifted > CP_MAX) ||
                        ((w_shifted >= CP_SURR_LO) && (w_shifted <= CP_SURR_HI))) begin
                        n_err = 1'b1;
                    end
                    n_len = SEQ_NONE;
                    n_acc = '0;
                end
            end
        end
        if (i_item.last) begin
            if (n_rem != 2'd0) begin
                n_err = 1'b1;
            end
            n_verdict = n_err ? VERDICT_INVALID : VERDICT_VALID;
            n_rem     = 2'd0;
            n_len     = SEQ_NONE;
            n_acc     = '0;
            n_err     = 1'b0;
        end else begin
            n_verdict = n_err ? VERDICT_INVALID : VERDICT_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= 2'd0;
            r_len       <= SEQ_NONE;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rem       <= n_rem;
                r_len       <= n_len;
                r_acc       <= n_acc;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict <= n_verdict;
            r_done    <= i_item.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_verdict};
    assign o_m_axis_tlast  = r_done;

endmodule

[rtl/utf8_stream_validator.sv]
// UTF-8 stream validator: checks a byte stream for well-formed UTF-8 with no NUL.
// Result path: each input byte is written to the queue, then popped into the verdict register.
// Throughput: one byte per cycle while results are accepted; output back-pressure stalls the back end.
// Reset: synchronous, active low; clears sequence state, error flag, queue and output valid.
// Depends on utf8v_pkg, utf8v_front, utf8v_queue and utf8v_back.
`timescale 1ns / 1ps

module utf8_stream_validator
    import utf8v_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // end_of_text
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [1:0] verdict, [7:2] zero
    output logic       o_m_axis_tlast    // text_done
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_q_valid;
    t_item w_in_item;
    t_item w_q_item;

    utf8v_front u_front (
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_full        (w_full),
        .o_push          (w_push),
        .o_item          (w_in_item)
    );

    utf8v_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    utf8v_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_item          (w_q_item),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

[tb/utf8_stream_validator_tb.sv]
// Self-checking testbench for utf8_stream_validator: directed texts, then random texts and noise bytes.
// Predicts each per-byte verdict in step with the sender; needs utf8v_pkg and the RTL.
`timescale 1ns / 1ps

module utf8_stream_validator_tb;
    import utf8v_pkg::*;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned IDLE_PCT     = 13;
    localparam int unsigned BYTES_TOTAL  = 1450;
    localparam int unsigned SETTLE_TICKS = 8;

    typedef struct packed {
        logic [1:0] verdict;
        logic       done;
    } t_verdict;

    typedef enum int unsigned {
        FLT_NONE,
        FLT_NUL,
        FLT_BAD_LEAD,
        FLT_STRAY_CONT,
        FLT_MISSING_CONT,
        FLT_OVERLONG,
        FLT_ABOVE_MAX,
        FLT_SURROGATE,
        FLT_CUT_SHORT,
        FLT_NOISE
    } t_fault;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = 8'h00;
    logic       i_s_axis_tlast  = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;

    // predictor state
    logic [1:0] pend_cont  = 2'd0;
    logic [1:0] seq_kind   = SEQ_NONE;
    t_acc       cp_bits    = '0;
    logic       err_sticky = 1'b0;

    t_verdict    verdict_q[$];
    logic [7:0]  text_buf[$];
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_cnt  = 0;
    logic        steady     = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    utf8_stream_validator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] data_byte
        .i_s_axis_tlast  (i_s_axis_tlast),   // end_of_text
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [1:0] verdict, [7:2] zero
        .o_m_axis_tlast  (o_m_axis_tlast)    // text_done
    );

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t ns: %s got %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    function automatic t_verdict predict_verdict(input logic [7:0] b, input logic eot);
        t_verdict res;
        t_acc     floor_cp;
        if (!err_sticky) begin
            if (pend_cont == 2'd0) begin
                if (b == 8'h00) begin
                    err_sticky = 1'b1;
                end else if (!b[7]) begin
                    // plain ASCII: nothing to gather
                end else if (b[7:5] == 3'b110) begin
                    pend_cont = 2'd1;
                    seq_kind  = SEQ_TWO;
                    cp_bits   = t_acc'(b[4:0]);
                end else if (b[7:4] == 4'b1110) begin
                    pend_cont = 2'd2;
                    seq_kind  = SEQ_THREE;
                    cp_bits   = t_acc'(b[3:0]);
                end else if (b[7:3] == 5'b11110) begin
                    pend_cont = 2'd3;
                    seq_kind  = SEQ_FOUR;
                    cp_bits   = t_acc'(b[2:0]);
                end else begin
                    err_sticky = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                // a non-continuation byte is not taken as a fresh lead
                err_sticky = 1'b1;
            end else begin
                cp_bits   = {cp_bits[ACC_W-7:0], b[5:0]};
                pend_cont = pend_cont - 2'd1;
                if (pend_cont == 2'd0) begin
                    floor_cp = (seq_kind == SEQ_TWO)   ? CP_MIN_TWO :
                               (seq_kind == SEQ_THREE) ? CP_MIN_THREE : CP_MIN_FOUR;
                    if (cp_bits < floor_cp || cp_bits > CP_MAX ||
                        (cp_bits >= CP_SURR_LO && cp_bits <= CP_SURR_HI))
                        err_sticky = 1'b1;
                    seq_kind = SEQ_NONE;
                    cp_bits  = '0;
                end
            end
        end
        if (eot) begin
            if (pend_cont != 2'd0)
                err_sticky = 1'b1;
            res.verdict = err_sticky ? VERDICT_INVALID : VERDICT_VALID;
            res.done    = 1'b1;
            pend_cont   = 2'd0;
            seq_kind    = SEQ_NONE;
            cp_bits     = '0;
            err_sticky  = 1'b0;
        end else begin
            res.verdict = err_sticky ? VERDICT_INVALID : VERDICT_BUSY;
            res.done    = 1'b0;
        end
        return res;
    endfunction

    // predict on every input transfer, check on every output transfer
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                verdict_q.insert(verdict_q.size(),
                                 predict_verdict(i_s_axis_tdata, i_s_axis_tlast));
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected result, tdata", 32'(o_m_axis_tdata), 32'd0);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_m_axis_tdata[1:0] !== want.verdict)
                        report_mismatch("verdict", 32'(o_m_axis_tdata[1:0]),
                                        32'(want.verdict));
                    if (o_m_axis_tlast !== want.done)
                        report_mismatch("text_done", 32'(o_m_axis_tlast), 32'(want.done));
                    if (o_m_axis_tdata[7:2] !== 6'd0)
                        report_mismatch("tdata padding", 32'(o_m_axis_tdata[7:2]), 32'd0);
                end
            end
        end
    end

    always @(posedge i_clk)
        i_m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // called at a rising edge; leaves tvalid high so back-to-back bytes need no re-raise
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
    endtask

    function automatic void append_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void append_seq(input logic [20:0] cp, input int unsigned len);
        case (len)
            1: append_byte(cp[7:0]);
            2: begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3: begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default: begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // legal code point for a given encoded length, leaning on the range edges now and then
    function automatic logic [20:0] random_code_point(input int unsigned len);
        logic [20:0] cp;
        logic        edge_pick;
        logic        hi;
        edge_pick = ($urandom_range(0, 3) == 0);
        hi        = 1'($urandom_range(0, 1));
        case (len)
            1: cp = edge_pick ? (hi ? 21'h7F : 21'h01) : 21'($urandom_range(1, 'h7F));
            2: cp = edge_pick ? (hi ? 21'h7FF : 21'h80) : 21'($urandom_range('h80, 'h7FF));
            3: begin
                if (edge_pick) begin
                    case ($urandom_range(0, 3))
                        0: cp = 21'h00800;
                        1: cp = 21'h0D7FF;
                        2: cp = 21'h0E000;
                        default: cp = 21'h0FFFF;
                    endcase
                end else begin
                    cp = 21'($urandom_range('h800, 'hFFFF));
                    // fold surrogates into the range below them
                    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                        cp = cp ^ 21'h01000;
                end
            end
            default: cp = edge_pick ? (hi ? CP_MAX : CP_MIN_FOUR)
                                    : 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // open sequence of random length, cut after one or more of its bytes
    function automatic void append_partial_seq();
        int unsigned len;
        int unsigned keep;
        int unsigned base;
        len  = $urandom_range(2, 4);
        keep = $urandom_range(1, len - 1);
        base = text_buf.size();
        append_seq(random_code_point(len), len);
        while (text_buf.size() > base + keep)
            void'(text_buf.pop_back());
    endfunction

    function automatic void append_fault(input t_fault flt);
        logic [7:0]  b;
        int unsigned len;
        case (flt)
            FLT_NUL:        append_byte(8'h00);
            FLT_BAD_LEAD:   append_byte(8'($urandom_range('hF8, 'hFF)));
            FLT_STRAY_CONT: append_byte({2'b10, 6'($urandom_range(0, 63))});
            FLT_MISSING_CONT: begin
                append_partial_seq();
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                append_byte(b);
            end
            FLT_OVERLONG: begin
                len = $urandom_range(2, 4);
                case (len)
                    2:       append_seq(21'($urandom_range(0, 'h7F)), len);
                    3:       append_seq(21'($urandom_range(0, 'h7FF)), len);
                    default: append_seq(21'($urandom_range(0, 'hFFFF)), len);
                endcase
            end
            FLT_ABOVE_MAX: append_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            FLT_SURROGATE: append_seq(21'($urandom_range('hD800, 'hDFFF)), 3);
            FLT_CUT_SHORT: append_partial_seq();
            FLT_NOISE: begin
                repeat ($urandom_range(1, 3))
                    append_byte(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endfunction

    // build a text of a few characters, one fault at a random place in about a third of them
    function automatic void build_text();
        int unsigned nchars;
        int unsigned at;
        int unsigned len;
        t_fault      flt;
        nchars = $urandom_range(1, 10);
        flt    = ($urandom_range(0, 99) < 65) ? FLT_NONE
                                              : t_fault'($urandom_range(FLT_NUL, FLT_NOISE));
        at     = (flt == FLT_CUT_SHORT) ? nchars : $urandom_range(0, nchars);
        for (int i = 0; i <= nchars; i++) begin
            if (i == at)
                append_fault(flt);
            if (i < nchars) begin
                len = $urandom_range(1, 4);
                append_seq(random_code_point(len), len);
            end
        end
    endfunction

    task automatic test_ascii_bounds();
        text_buf = '{8'h01, 8'h7F, 8'h41};
        send_text();
        text_buf = '{8'h00};
        send_text();
    endtask

    task automatic test_bad_leads();
        text_buf = '{8'h80};
        send_text();
        // error stays until the end of text
        text_buf = '{8'hFF, 8'h41};
        send_text();
    endtask

    task automatic test_sequence_faults();
        text_buf = '{8'hC3, 8'h41};
        send_text();
        text_buf = '{8'hC2, 8'h00};
        send_text();
        text_buf = '{8'hC0, 8'h80};
        send_text();
        text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_text();
        text_buf = '{8'hED, 8'hA0, 8'h80};
        send_text();
        text_buf = '{8'hE2, 8'h82};
        send_text();
    endtask

    task automatic test_valid_sequences();
        text_buf = '{8'hC2, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80};
        send_text();
    endtask

    task automatic test_random_texts(input int unsigned goal);
        while (bytes_sent < goal) begin
            build_text();
            send_text();
        end
    endtask

    task automatic test_pause_until_drained();
        repeat (6) begin
            build_text();
            send_text();
        end
        wait_results_drained();
        repeat (6) begin
            build_text();
            send_text();
        end
    endtask

    task automatic test_noise_bytes(input int unsigned goal);
        while (bytes_sent < goal)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        // close the last noise text
        send_byte(8'h41, 1'b1);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_bounds();
        test_bad_leads();
        test_sequence_faults();
        test_valid_sequences();

        test_random_texts(450);
        steady = 1'b1;
        test_random_texts(750);
        steady = 1'b0;
        test_pause_until_drained();
        test_noise_bytes(1100);
        test_random_texts(BYTES_TOTAL);

        wait_results_drained();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
